### rtl/core/nes_pkg.sv
package nes_pkg;

  // table and entity sizes
  localparam int unsigned RowAw  = 16;
  localparam int unsigned EntAw  = 14;
  localparam int unsigned RelW   = 10;
  localparam int unsigned RowW   = RelW + EntAw;
  localparam int unsigned RngW   = 2 * RowAw;
  localparam int unsigned CntW   = 15;

  localparam logic [CntW-1:0] EntityCountRst = 15'd16384;
  localparam logic [CntW-1:0] MaxEntities    = 15'd16384;

  // lcg constants
  localparam logic [34:0] LcgMul  = 35'd25214903917;
  localparam logic [63:0] LcgAdd  = 64'd11;
  localparam logic [63:0] LcgSeed = 64'd3;

  // request codes
  localparam logic [2:0] ReqHeadRow   = 3'd0;
  localparam logic [2:0] ReqTailRow   = 3'd1;
  localparam logic [2:0] ReqHeadRng   = 3'd2;
  localparam logic [2:0] ReqTailRng   = 3'd3;
  localparam logic [2:0] ReqSampTail  = 3'd4;
  localparam logic [2:0] ReqSampHead  = 3'd5;

  // search phases
  localparam logic [1:0] PhRelLo  = 2'd0;
  localparam logic [1:0] PhRelHi  = 2'd1;
  localparam logic [1:0] PhSkip   = 2'd2;

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StRange   = 11'b000_0000_0010,
    StRngChk  = 11'b000_0000_0100,
    StSrch    = 11'b000_0000_1000,
    StSrchCmp = 11'b000_0001_0000,
    StFree    = 11'b000_0010_0000,
    StMul     = 11'b000_0100_0000,
    StDiv     = 11'b000_1000_0000,
    StPll     = 11'b001_0000_0000,
    StPrr     = 11'b010_0000_0000,
    StPrrChk  = 11'b100_0000_0000
  } state_e;

endpackage

### rtl/core/nes_ram.sv
module nes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/negative_entity_sampler_top.sv
// Negative entity sampler. Write requests load rows of the head- and tail-sorted
// triple tables and per-entity row ranges; each is acknowledged in the cycle after
// transfer. A sample request reads the key's range, runs two binary searches over
// the key's row block for the relation (skipped for an empty block), checks the
// free-entity count, advances the 64-bit LCG by 16x35 partial products and reduces
// it modulo the free-entity count with a bit-serial divider. When the key has
// partners for the relation, the block ends are read and at most one more binary
// search skips the known partners.
// One request is worked at a time; a new one is taken the cycle after the
// previous answer is transferred.
module negative_entity_sampler_top
  import nes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       req_type_i,
  input  logic [RowAw-1:0] row_index_i,
  input  logic [EntAw-1:0] key_entity_i,
  input  logic [RelW-1:0]  relation_i,
  input  logic [EntAw-1:0] partner_entity_i,
  input  logic [RowAw-1:0] range_first_i,
  input  logic [RowAw-1:0] range_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [EntAw-1:0] sampled_entity_o,
  output logic             is_sample_o,
  output logic             no_candidate_o
);

  state_e state_q;
  logic [CntW-1:0] ent_cnt_q;
  logic out_valid_q;
  logic [EntAw-1:0] res_q;
  logic is_samp_q, no_cand_q;
  logic tab_q;
  logic [EntAw-1:0] key_q;
  logic [RelW-1:0] rel_q;
  logic signed [19:0] lo_q, hi_q, count_q;
  logic [RowAw-1:0] mid_q, first_q, last_q, ll_q, rr_q;
  logic [1:0] phase_q;
  logic [CntW-1:0] freec_q;
  logic [63:0] lcg_q, acc_q, div_sh_q;
  logic [1:0] mul_cnt_q;
  logic [5:0] div_cnt_q;
  logic [EntAw-1:0] rem_q, tmp_q, pll_q;

  logic in_acc;
  logic row_we, rng_we;
  logic [RowAw:0] row_waddr, row_raddr;
  logic [EntAw:0] rng_waddr;
  logic [RowW-1:0] row_rd;
  logic [RngW-1:0] rng_rd;
  logic [RowAw-1:0] row_addr_c;

  // input transfer only when idle and the answer slot is empty
  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign in_acc = in_valid_i && !in_stall_o;

  // table writes happen on the transfer edge
  assign row_we = in_acc && ((req_type_i == ReqHeadRow) || (req_type_i == ReqTailRow));
  assign rng_we = in_acc && ((req_type_i == ReqHeadRng) || (req_type_i == ReqTailRng))
                  && (row_index_i[RowAw-1:EntAw] == '0);
  assign row_waddr = {req_type_i[0], row_index_i};
  assign rng_waddr = {req_type_i[0], row_index_i[EntAw-1:0]};

  // search datapath
  logic signed [19:0] sum_c, mid_c, ll_s, rr_s, tmp_s, part_s, mid_s, skip_c, prr_lim_c;
  logic signed [19:0] freec_c, ent_s;
  logic srch_go;
  logic [RelW-1:0] rel_rd;
  assign sum_c   = lo_q + hi_q;
  assign mid_c   = sum_c >>> 1;
  assign srch_go = (lo_q + 20'sd1) < hi_q;
  assign rel_rd  = row_rd[RowW-1:EntAw];
  assign ll_s    = $signed({4'b0, ll_q});
  assign rr_s    = $signed({4'b0, rr_q});
  assign tmp_s   = $signed({6'b0, tmp_q});
  assign part_s  = $signed({6'b0, row_rd[EntAw-1:0]});
  assign mid_s   = $signed({4'b0, mid_q});
  assign skip_c  = part_s - mid_s + ll_s - 20'sd1;
  assign prr_lim_c = part_s - rr_s + ll_s - 20'sd1;
  assign ent_s   = $signed({5'b0, (ent_cnt_q > MaxEntities) ? MaxEntities : ent_cnt_q});
  assign freec_c = ent_s - count_q;

  // row read address by state
  always_comb begin
    case (state_q)
      StPll:   row_addr_c = ll_q;
      StPrr:   row_addr_c = rr_q;
      default: row_addr_c = mid_c[RowAw-1:0];
    endcase
  end
  assign row_raddr = {tab_q, row_addr_c};

  nes_ram #(.Width(RowW), .Depth(2 ** (RowAw + 1))) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i ({relation_i, partner_entity_i}),
    .raddr_i (row_raddr),
    .rdata_o (row_rd)
  );

  nes_ram #(.Width(RngW), .Depth(2 ** (EntAw + 1))) u_ranges (
    .clk_i   (clk_i),
    .we_i    (rng_we),
    .waddr_i (rng_waddr),
    .wdata_i ({range_last_i, range_first_i}),
    .raddr_i ({tab_q, key_q}),
    .rdata_o (rng_rd)
  );

  // lcg partial product
  logic [15:0] digit_c;
  logic [50:0] prod_c;
  logic [63:0] acc_d;
  assign digit_c = lcg_q[{mul_cnt_q, 4'b0} +: 16];
  assign prod_c  = digit_c * LcgMul;
  assign acc_d   = acc_q + (64'(prod_c) << {mul_cnt_q, 4'b0});

  // restoring divide step
  logic [CntW-1:0] trial_c;
  logic [EntAw-1:0] rem_d;
  assign trial_c = {rem_q, div_sh_q[63]};
  assign rem_d   = (trial_c >= freec_q) ? 14'(trial_c - freec_q) : trial_c[EntAw-1:0];

  logic signed [19:0] cnt_c, res_p2;
  assign cnt_c  = lo_q - ll_s + 20'sd1;
  assign res_p2 = tmp_s + lo_q - ll_s + 20'sd1;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ent_cnt_q   <= EntityCountRst;
      out_valid_q <= 1'b0;
      lcg_q       <= LcgSeed;
      phase_q     <= PhRelLo;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
      res_q       <= '0;
      is_samp_q   <= 1'b0;
      no_cand_q   <= 1'b0;
      tab_q       <= 1'b0;
      key_q       <= '0;
      rel_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      count_q     <= '0;
      mid_q       <= '0;
      first_q     <= '0;
      last_q      <= '0;
      ll_q        <= '0;
      rr_q        <= '0;
      freec_q     <= '0;
      acc_q       <= '0;
      div_sh_q    <= '0;
      rem_q       <= '0;
      tmp_q       <= '0;
      pll_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        ent_cnt_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            tab_q <= req_type_i[0];
            key_q <= key_entity_i;
            rel_q <= relation_i;
            if ((req_type_i == ReqSampTail) || (req_type_i == ReqSampHead)) begin
              state_q <= StRange;
            end else begin
              out_valid_q <= 1'b1;
              res_q       <= '0;
              is_samp_q   <= 1'b0;
              no_cand_q   <= 1'b0;
            end
          end
        end
        StRange: state_q <= StRngChk;
        StRngChk: begin
          first_q <= rng_rd[RowAw-1:0];
          last_q  <= rng_rd[RngW-1:RowAw];
          if (rng_rd[RngW-1:RowAw] < rng_rd[RowAw-1:0]) begin
            count_q <= '0;
            state_q <= StFree;
          end else begin
            lo_q    <= $signed({4'b0, rng_rd[RowAw-1:0]}) - 20'sd1;
            hi_q    <= $signed({4'b0, rng_rd[RngW-1:RowAw]});
            phase_q <= PhRelLo;
            state_q <= StSrch;
          end
        end
        StSrch: begin
          if (srch_go) begin
            mid_q   <= mid_c[RowAw-1:0];
            state_q <= StSrchCmp;
          end else begin
            case (phase_q)
              PhRelLo: begin
                ll_q    <= hi_q[RowAw-1:0];
                lo_q    <= $signed({4'b0, first_q});
                hi_q    <= $signed({4'b0, last_q}) + 20'sd1;
                phase_q <= PhRelHi;
              end
              PhRelHi: begin
                rr_q    <= lo_q[RowAw-1:0];
                count_q <= (cnt_c < 0) ? 20'sd0 : cnt_c;
                state_q <= StFree;
              end
              default: begin
                out_valid_q <= 1'b1;
                res_q       <= res_p2[EntAw-1:0];
                is_samp_q   <= 1'b1;
                no_cand_q   <= 1'b0;
                state_q     <= StIdle;
              end
            endcase
          end
        end
        StSrchCmp: begin
          state_q <= StSrch;
          case (phase_q)
            PhRelLo: begin
              if (rel_rd >= rel_q) hi_q <= mid_s; else lo_q <= mid_s;
            end
            PhRelHi: begin
              if (rel_rd <= rel_q) lo_q <= mid_s; else hi_q <= mid_s;
            end
            default: begin
              if (skip_c < tmp_s) lo_q <= mid_s; else hi_q <= mid_s;
            end
          endcase
        end
        StFree: begin
          if (freec_c <= 0) begin
            out_valid_q <= 1'b1;
            res_q       <= '0;
            is_samp_q   <= 1'b1;
            no_cand_q   <= 1'b1;
            state_q     <= StIdle;
          end else begin
            freec_q   <= freec_c[CntW-1:0];
            acc_q     <= LcgAdd;
            mul_cnt_q <= '0;
            state_q   <= StMul;
          end
        end
        StMul: begin
          acc_q     <= acc_d;
          mul_cnt_q <= mul_cnt_q + 2'd1;
          if (mul_cnt_q == 2'd3) begin
            lcg_q     <= acc_d;
            div_sh_q  <= acc_d;
            div_cnt_q <= 6'd63;
            rem_q     <= '0;
            state_q   <= StDiv;
          end
        end
        StDiv: begin
          rem_q     <= rem_d;
          div_sh_q  <= {div_sh_q[62:0], 1'b0};
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == '0) begin
            tmp_q <= rem_d;
            if (count_q == 0) begin
              out_valid_q <= 1'b1;
              res_q       <= rem_d;
              is_samp_q   <= 1'b1;
              no_cand_q   <= 1'b0;
              state_q     <= StIdle;
            end else begin
              state_q <= StPll;
            end
          end
        end
        StPll: state_q <= StPrr;
        StPrr: begin
          pll_q   <= row_rd[EntAw-1:0];
          state_q <= StPrrChk;
        end
        StPrrChk: begin
          if (tmp_q < pll_q) begin
            out_valid_q <= 1'b1;
            res_q       <= tmp_q;
            is_samp_q   <= 1'b1;
            no_cand_q   <= 1'b0;
            state_q     <= StIdle;
          end else if (tmp_s > prr_lim_c) begin
            out_valid_q <= 1'b1;
            res_q       <= tmp_q + count_q[EntAw-1:0];
            is_samp_q   <= 1'b1;
            no_cand_q   <= 1'b0;
            state_q     <= StIdle;
          end else begin
            lo_q    <= ll_s;
            hi_q    <= rr_s + 20'sd1;
            phase_q <= PhSkip;
            state_q <= StSrch;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sampled_entity_o = res_q;
  assign is_sample_o      = is_samp_q;
  assign no_candidate_o   = no_cand_q;

  // no-candidate answers are samples with a zero entity
  a_nocand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_candidate_o |-> is_sample_o && (sampled_entity_o == '0))
    else $error("no-candidate answer malformed");

  // a transfer starts work or posts an acknowledge
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != StIdle) || out_valid_q)
    else $error("transfer left no trace");

  // divider only runs with a nonzero divisor
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (freec_q != '0))
    else $error("divide by zero count");

endmodule

### verif/nes_sample_checker.sv
module nes_sample_checker
  import nes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CntW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [2:0]       req_type_i,
  input  logic [RowAw-1:0] row_index_i,
  input  logic [EntAw-1:0] key_entity_i,
  input  logic [RelW-1:0]  relation_i,
  input  logic [EntAw-1:0] partner_entity_i,
  input  logic [RowAw-1:0] range_first_i,
  input  logic [RowAw-1:0] range_last_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [EntAw-1:0] sampled_entity_i,
  input  logic             is_sample_i,
  input  logic             no_candidate_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic [EntAw-1:0] entity;
    logic             is_samp;
    logic             no_cand;
  } answer_t;

  // mirrored tables, index 0 is head-sorted and 1 is tail-sorted
  logic [RowW-1:0] rows_q [2][65536];
  logic [RngW-1:0] ranges_q [2][16384];
  logic [63:0]     lcg_q;
  logic [CntW-1:0] ent_count_q;
  answer_t         answers_due[$];

  function automatic longint row_rel(int t, longint i);
    if (i < 0 || i > 65535) return 0;
    return longint'(rows_q[t][i][RowW-1:EntAw]);
  endfunction

  function automatic longint row_partner(int t, longint i);
    if (i < 0 || i > 65535) return 0;
    return longint'(rows_q[t][i][EntAw-1:0]);
  endfunction

  // free-entity draw that skips the key's known partners for the relation
  function automatic answer_t predict_draw(int t, logic [EntAw-1:0] key,
                                           logic [RelW-1:0] rel_in);
    longint  first, last, lo, hi, mid, ll, rr, cnt, ent, freec, tmp, res, rel;
    answer_t a;
    rel   = longint'(rel_in);
    first = longint'(ranges_q[t][key][15:0]);
    last  = longint'(ranges_q[t][key][31:16]);
    cnt   = 0;
    ll    = 0;
    rr    = -1;
    if (last >= first) begin
      lo = first - 1;
      hi = last;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (row_rel(t, mid) >= rel) hi = mid; else lo = mid;
      end
      ll = hi;
      lo = first;
      hi = last + 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (row_rel(t, mid) <= rel) lo = mid; else hi = mid;
      end
      rr  = lo;
      cnt = rr - ll + 1;
      if (cnt < 0) cnt = 0;
    end
    ent = longint'(ent_count_q);
    if (ent > longint'(MaxEntities)) ent = longint'(MaxEntities);
    freec     = ent - cnt;
    a.is_samp = 1'b1;
    if (freec <= 0) begin
      a.entity  = '0;
      a.no_cand = 1'b1;
      return a;
    end
    lcg_q = lcg_q * 64'(LcgMul) + LcgAdd;
    tmp   = longint'(lcg_q % 64'(freec));
    if (cnt == 0) begin
      res = tmp;
    end else if (tmp < row_partner(t, ll)) begin
      res = tmp;
    end else if (tmp > row_partner(t, rr) - rr + ll - 1) begin
      res = tmp + cnt;
    end else begin
      lo = ll;
      hi = rr + 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (row_partner(t, mid) - mid + ll - 1 < tmp) lo = mid; else hi = mid;
      end
      res = tmp + lo - ll + 1;
    end
    a.entity  = res[EntAw-1:0];
    a.no_cand = 1'b0;
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      lcg_q       = LcgSeed;
      ent_count_q = EntityCountRst;
      answers_due.delete();
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      // result transfer against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result, sampled_entity", sampled_entity_i, 0);
        end else begin
          want = answers_due.pop_front();
          if (sampled_entity_i !== want.entity)
            report_mismatch("sampled_entity", sampled_entity_i, want.entity);
          if (is_sample_i !== want.is_samp)
            report_mismatch("is_sample", is_sample_i, want.is_samp);
          if (no_candidate_i !== want.no_cand)
            report_mismatch("no_candidate", no_candidate_i, want.no_cand);
        end
      end
      if (cfg_we_i) ent_count_q = cfg_wdata_i;
      // request transfer
      if (in_valid_i && !in_stall_i) begin
        want = '0;
        case (req_type_i)
          ReqHeadRow:  rows_q[0][row_index_i] = {relation_i, partner_entity_i};
          ReqTailRow:  rows_q[1][row_index_i] = {relation_i, partner_entity_i};
          ReqHeadRng: begin
            if (row_index_i < 16384)
              ranges_q[0][row_index_i[EntAw-1:0]] = {range_last_i, range_first_i};
          end
          ReqTailRng: begin
            if (row_index_i < 16384)
              ranges_q[1][row_index_i[EntAw-1:0]] = {range_last_i, range_first_i};
          end
          ReqSampTail: want = predict_draw(0, key_entity_i, relation_i);
          ReqSampHead: want = predict_draw(1, key_entity_i, relation_i);
          default: ;
        endcase
        answers_due.insert(answers_due.size(), want);
      end
      pending_o = answers_due.size();
    end
  end

endmodule

### verif/negative_entity_sampler_top_tb.sv
module negative_entity_sampler_top_tb;
  import nes_pkg::*;

  localparam logic [2:0] ReqBadLo = 3'd6;
  localparam logic [2:0] ReqBadHi = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CntW-1:0]  cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [2:0]       req_type_i;
  logic [RowAw-1:0] row_index_i;
  logic [EntAw-1:0] key_entity_i;
  logic [RelW-1:0]  relation_i;
  logic [EntAw-1:0] partner_entity_i;
  logic [RowAw-1:0] range_first_i;
  logic [RowAw-1:0] range_last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [EntAw-1:0] sampled_entity_o;
  logic             is_sample_o;
  logic             no_candidate_o;
  int               errors;
  int               pending;

  // which rows and ranges are written, so no sample reads an unwritten entry
  bit               row_set [2][65536];
  bit               key_ok [2][16384];
  logic [RelW-1:0]  key_rel_lo [2][16384];
  logic [RelW-1:0]  key_rel_hi [2][16384];
  int               safe_keys [2][$];
  int               items_sent;
  bit               calm_in;

  negative_entity_sampler_top dut (.*);

  nes_sample_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .row_index_i, .key_entity_i,
    .relation_i, .partner_entity_i, .range_first_i, .range_last_i,
    .out_valid_i(out_valid_o), .out_stall_i, .sampled_entity_i(sampled_entity_o),
    .is_sample_i(is_sample_o), .no_candidate_i(no_candidate_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("** negative_entity_sampler_top: FAILED **");
    $finish;
  end

  // receiver stalls: bursts of random length with calm stretches
  initial begin
    int n;
    int r;
    out_stall_i = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i = 1'b0;
        n = $urandom_range(1, 4);
      end else if (r < 85) begin
        out_stall_i = 1'b1;
        n = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall_i = 1'b0;
        n = $urandom_range(50, 400);
      end else begin
        out_stall_i = 1'b1;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(negedge clk_i);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request transfer; returns right after the accepting edge
  task automatic send(logic [2:0] req, logic [15:0] idx, logic [13:0] key,
                      logic [9:0] rel, logic [13:0] partner,
                      logic [15:0] first, logic [15:0] last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_type_i       = req;
    row_index_i      = idx;
    key_entity_i     = key;
    relation_i       = rel;
    partner_entity_i = partner;
    range_first_i    = first;
    range_last_i     = last;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic put_row(int t, logic [15:0] idx, logic [9:0] rel, logic [13:0] partner);
    send(t ? ReqTailRow : ReqHeadRow, idx, 14'($urandom), rel, partner,
         16'($urandom), 16'($urandom));
    row_set[t][idx] = 1'b1;
  endtask

  task automatic put_range(int t, logic [15:0] ent, logic [15:0] first, logic [15:0] last);
    bit ok;
    send(t ? ReqTailRng : ReqHeadRng, ent, 14'($urandom), 10'($urandom),
         14'($urandom), first, last);
    if (ent < 16384) begin
      ok = (last < first);
      if (!ok && (last - first) <= 512) begin
        ok = 1'b1;
        for (int i = first; i <= last; i++) if (!row_set[t][i]) ok = 1'b0;
      end
      key_ok[t][ent] = ok;
      if (ok) safe_keys[t].insert(safe_keys[t].size(), int'(ent));
    end
  endtask

  // sorted block of rows for one key: relation ascending, partners ascending within each relation
  task automatic build_block(int t, logic [13:0] key, int n, int rel0, int p0);
    int base;
    int rel;
    int p;
    base = $urandom_range(1, 65535 - n);
    rel  = rel0;
    p    = p0;
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 3) == 0 && rel < 1023) begin
          rel = rel + 1;
          p   = $urandom_range(0, 6);
        end else begin
          p = p + 1 + $urandom_range(0, 3);
          if (p > 16383) p = 16383;
        end
      end
      put_row(t, 16'(base + i), 10'(rel), 14'(p));
    end
    if (n == 0) put_range(t, key, 16'(base + 1), 16'(base));
    else put_range(t, key, 16'(base), 16'(base + n - 1));
    key_rel_lo[t][key] = 10'(rel0);
    key_rel_hi[t][key] = 10'(rel);
  endtask

  task automatic ask(int t, logic [13:0] key, logic [9:0] rel);
    send(t ? ReqSampHead : ReqSampTail, 16'($urandom), key, rel, 14'($urandom),
         16'($urandom), 16'($urandom));
  endtask

  // register write only with nothing in flight
  task automatic set_count(logic [CntW-1:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic random_item();
    int r;
    int t;
    int n;
    int key;
    int lo;
    int hi;
    int rel;
    logic [15:0] f;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, 1);
    if (r < 75 && r >= 25 && safe_keys[t].size() > 0) begin
      key = safe_keys[t][$urandom_range(0, safe_keys[t].size() - 1)];
      if (!key_ok[t][key]) begin
        put_row(t, 16'($urandom), 10'($urandom), 14'($urandom));
        return;
      end
      lo = key_rel_lo[t][key];
      hi = key_rel_hi[t][key];
      n  = $urandom_range(0, 9);
      if (n < 6) rel = $urandom_range(lo, hi);
      else if (n < 8) rel = (n == 6) ? ((lo > 0) ? lo - 1 : 0) : ((hi < 1023) ? hi + 1 : hi);
      else rel = $urandom_range(0, 1023);
      ask(t, 14'(key), 10'(rel));
    end else if (r < 75) begin
      n = $urandom_range(0, 99);
      if (n < 80) n = $urandom_range(0, 10);
      else if (n < 97) n = $urandom_range(11, 60);
      else n = $urandom_range(61, 300);
      rel = ($urandom_range(0, 4) == 0) ? 1023 - $urandom_range(0, 3) : $urandom_range(0, 1023);
      build_block(t, 14'($urandom), n, rel,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15000) : $urandom_range(0, 8));
    end else if (r < 85) begin
      put_row(t, 16'($urandom), 10'($urandom), 14'($urandom));
    end else if (r < 93) begin
      f = 16'($urandom);
      put_range(t, ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383)),
                f, ($urandom_range(0, 1) == 0) ? 16'(f + $urandom_range(0, 20)) : 16'($urandom));
    end else begin
      send(($urandom_range(0, 1) == 0) ? ReqBadLo : ReqBadHi, 16'($urandom), 14'($urandom),
           10'($urandom), 14'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [CntW-1:0] counts [9];
    int k;
    counts = '{15'd20, 15'd16384, 15'd1, 15'd3, 15'd32767, 15'd700, 15'd0, 15'd16383, 15'd50};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    row_index_i = '0;
    key_entity_i = '0;
    relation_i = '0;
    partner_entity_i = '0;
    range_first_i = '0;
    range_last_i = '0;
    items_sent = 0;
    calm_in = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: small blocks at field extremes, absent relation, empty block,
    // ignored writes, unknown requests, no free entity, count above the maximum
    set_count(15'd16384);
    build_block(0, 14'd0, 3, 0, 0);
    build_block(1, 14'd16383, 2, 1023, 16382);
    build_block(0, 14'd7, 0, 0, 0);
    ask(0, 14'd0, 10'd0);
    ask(0, 14'd0, 10'd5);
    ask(1, 14'd16383, 10'd1023);
    ask(0, 14'd7, 10'd0);
    put_row(0, 16'hffff, 10'h3ff, 14'h3fff);
    put_range(0, 16'd16384, 16'hffff, 16'hffff);
    put_range(1, 16'hffff, 16'd0, 16'hffff);
    send(ReqBadLo, 16'hffff, 14'h3fff, 10'h3ff, 14'h3fff, 16'hffff, 16'hffff);
    send(ReqBadHi, '0, '0, '0, '0, '0, '0);
    set_count(15'd1);
    ask(0, 14'd0, 10'd0);
    ask(0, 14'd0, 10'd9);
    set_count(15'd0);
    ask(1, 14'd16383, 10'd1023);
    set_count(15'd32767);
    ask(0, 14'd0, 10'd0);

    // random phases, each under its own entity count, sharing the item budget
    foreach (counts[i]) begin
      set_count(counts[i]);
      k = 0;
      while (items_sent < (i + 1) * 215) begin
        if (k % 60 == 0) calm_in = ($urandom_range(0, 3) == 0);
        random_item();
        k++;
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("** negative_entity_sampler_top: PASSED **");
    end else begin
      $display("** negative_entity_sampler_top: FAILED **");
    end
    $finish;
  end

endmodule
